// ----- hw/rtl/aid_pkg.sv -----
// shared types and codes for the instruction decoder with barrel shifter
// no dependencies; used by aid_decode, aid_shifter and arm_instruction_decode
package aid_pkg;

  localparam int InWidth  = 104;
  localparam int OutWidth = 96;

  localparam logic [2:0] KIND_BRANCH      = 3'd0;
  localparam logic [2:0] KIND_TRANSFER    = 3'd1;
  localparam logic [2:0] KIND_MUL         = 3'd2;
  localparam logic [2:0] KIND_DATA        = 3'd3;
  localparam logic [2:0] KIND_HALT        = 3'd4;
  localparam logic [2:0] KIND_UNSUPPORTED = 3'd5;

  localparam logic [1:0] TOP_XFER  = 2'b01;
  localparam logic [1:0] TOP_BR    = 2'b10;
  localparam logic [1:0] TOP_COPRO = 2'b11;

  localparam logic [31:0] MUL_MASK  = 32'h0fc000f0;
  localparam logic [31:0] MUL_MATCH = 32'h00000090;

  localparam logic [3:0] COND_EQ = 4'd0;
  localparam logic [3:0] COND_NE = 4'd1;
  localparam logic [3:0] COND_CS = 4'd2;
  localparam logic [3:0] COND_CC = 4'd3;
  localparam logic [3:0] COND_MI = 4'd4;
  localparam logic [3:0] COND_PL = 4'd5;
  localparam logic [3:0] COND_VS = 4'd6;
  localparam logic [3:0] COND_VC = 4'd7;
  localparam logic [3:0] COND_HI = 4'd8;
  localparam logic [3:0] COND_LS = 4'd9;
  localparam logic [3:0] COND_GE = 4'd10;
  localparam logic [3:0] COND_LT = 4'd11;
  localparam logic [3:0] COND_GT = 4'd12;
  localparam logic [3:0] COND_LE = 4'd13;
  localparam logic [3:0] COND_AL = 4'd14;

  localparam logic [1:0] SHIFT_LSL = 2'd0;
  localparam logic [1:0] SHIFT_LSR = 2'd1;
  localparam logic [1:0] SHIFT_ASR = 2'd2;
  localparam logic [1:0] SHIFT_ROR = 2'd3;

  typedef struct packed {
    logic [31:0] offset_value;
    logic [5:0]  flag_bits;
    logic [3:0]  opcode_field;
    logic        regs_valid;
    logic [3:0]  second_reg;
    logic [3:0]  first_reg;
    logic [3:0]  dest_reg;
    logic        cond_pass;
    logic [2:0]  inst_kind;
  } dec_t;

  typedef struct packed {
    logic        shifted_carry;
    logic [31:0] shifted_value;
    dec_t        dec;
  } result_t;

  typedef struct packed {
    logic [31:0] rs_value;
    logic [31:0] rm_value;
    logic [3:0]  flags_nzcv;
    logic [31:0] instruction;
  } item_t;

endpackage

// ----- hw/rtl/aid_decode.sv -----
// instruction classification, condition check and field extraction
// depends on aid_pkg
module aid_decode import aid_pkg::*; (
  input  logic [31:0] instruction,
  input  logic [3:0]  flags_nzcv,
  output dec_t        dec
);

  logic [2:0] kind;
  logic       n, z, c, v;
  logic       pass;
  logic [63:0] imm_rot;

  assign n = flags_nzcv[3];
  assign z = flags_nzcv[2];
  assign c = flags_nzcv[1];
  assign v = flags_nzcv[0];

  always_comb begin
    if (instruction[27:26] == TOP_BR) begin
      kind = KIND_BRANCH;
    end else if (instruction[27:26] == TOP_XFER) begin
      kind = KIND_TRANSFER;
    end else if (instruction[27:26] == TOP_COPRO) begin
      kind = KIND_UNSUPPORTED;
    end else if ((instruction & MUL_MASK) == MUL_MATCH) begin
      kind = KIND_MUL;
    end else if (instruction == 32'd0) begin
      kind = KIND_HALT;
    end else begin
      kind = KIND_DATA;
    end
  end

  always_comb begin
    case (instruction[31:28])
      COND_EQ: pass = z;
      COND_NE: pass = !z;
      COND_CS: pass = c;
      COND_CC: pass = !c;
      COND_MI: pass = n;
      COND_PL: pass = !n;
      COND_VS: pass = v;
      COND_VC: pass = !v;
      COND_HI: pass = c && !z;
      COND_LS: pass = !c || z;
      COND_GE: pass = (n == v);
      COND_LT: pass = (n != v);
      COND_GT: pass = (n == v) && !z;
      COND_LE: pass = (n != v) || z;
      COND_AL: pass = 1'b1;
      default: pass = 1'b0;
    endcase
  end

  // immediate rotated right by twice the rotate field
  assign imm_rot = {24'd0, instruction[7:0], 24'd0, instruction[7:0]}
                   >> {instruction[11:8], 1'b0};

  always_comb begin
    dec              = '0;
    dec.inst_kind    = kind;
    dec.cond_pass    = pass;
    dec.second_reg   = instruction[3:0];
    case (kind)
      KIND_DATA: begin
        dec.dest_reg     = instruction[15:12];
        dec.first_reg    = instruction[19:16];
        dec.regs_valid   = 1'b1;
        dec.opcode_field = instruction[24:21];
        dec.flag_bits    = {instruction[25], instruction[20], 4'b0000};
        dec.offset_value = imm_rot[31:0];
      end
      KIND_TRANSFER: begin
        dec.dest_reg     = instruction[15:12];
        dec.first_reg    = instruction[19:16];
        dec.regs_valid   = 1'b1;
        dec.flag_bits    = {instruction[25], 2'b00, instruction[24], instruction[23],
                            instruction[20]};
        dec.offset_value = {20'd0, instruction[11:0]};
      end
      KIND_MUL: begin
        dec.dest_reg     = instruction[19:16];
        dec.first_reg    = instruction[15:12];
        dec.regs_valid   = 1'b1;
        dec.flag_bits    = {1'b0, instruction[20], instruction[21], 3'b000};
      end
      KIND_BRANCH: begin
        dec.offset_value = {8'd0, instruction[23:0]};
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hw/rtl/aid_shifter.sv -----
// barrel shifter for the operand register with carry out
// depends on aid_pkg
module aid_shifter import aid_pkg::*; (
  input  logic [31:0] instruction,
  input  logic        carry_in,
  input  logic [31:0] rm_value,
  input  logic [31:0] rs_value,
  output logic [31:0] shifted_value,
  output logic        shifted_carry
);

  logic [7:0]  amt;
  logic [4:0]  amt_lo;
  logic        big;
  logic        sign;
  logic [32:0] lsl_w;
  logic [32:0] lsr_w;
  logic [32:0] asr_w;
  logic [63:0] ror_w;

  assign amt    = instruction[4] ? rs_value[7:0] : {3'd0, instruction[11:7]};
  assign amt_lo = amt[4:0];
  assign big    = (amt[7:5] != 3'd0);
  assign sign   = rm_value[31];

  assign lsl_w = {1'b0, rm_value} << amt_lo;
  assign lsr_w = {rm_value, 1'b0} >> amt_lo;
  assign asr_w = 33'($signed({rm_value, 1'b0}) >>> amt_lo);
  assign ror_w = {rm_value, rm_value} >> amt_lo;

  always_comb begin
    shifted_value = rm_value;
    shifted_carry = carry_in;
    if (amt != 8'd0) begin
      case (instruction[6:5])
        SHIFT_LSL: begin
          if (!big) begin
            shifted_value = lsl_w[31:0];
            shifted_carry = lsl_w[32];
          end else begin
            shifted_value = 32'd0;
            shifted_carry = (amt == 8'd32) ? rm_value[0] : 1'b0;
          end
        end
        SHIFT_LSR: begin
          if (!big) begin
            shifted_value = lsr_w[32:1];
            shifted_carry = lsr_w[0];
          end else begin
            shifted_value = 32'd0;
            shifted_carry = (amt == 8'd32) ? sign : 1'b0;
          end
        end
        SHIFT_ASR: begin
          if (!big) begin
            shifted_value = asr_w[32:1];
            shifted_carry = asr_w[0];
          end else begin
            shifted_value = {32{sign}};
            shifted_carry = sign;
          end
        end
        default: begin
          shifted_value = ror_w[31:0];
          shifted_carry = ror_w[31];
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/arm_instruction_decode.sv -----
// Instruction decoder with barrel shifter. Each item carries an instruction word, the NZCV
// flags and the Rm and Rs register values; each result gives the class, condition pass,
// register numbers, opcode, flag bits, offset and the shifted Rm with its carry. One item is
// taken every clock cycle while results are taken: the decode and shifter logic sits between
// an input register and an output register, so the result of an accepted item passes through
// both registers before it shows on the master side. While a result waits to be taken the input register
// still takes one more item, after which the slave side stalls until the result is taken.
// top level; depends on aid_pkg, aid_decode and aid_shifter
module arm_instruction_decode import aid_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // instruction[31:0], flags_nzcv[35:32], rm_value[67:36], rs_value[99:68], zero pad
  input  logic [InWidth-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // inst_kind[2:0], cond_pass[3], dest_reg[7:4], first_reg[11:8], second_reg[15:12],
  // regs_valid[16], opcode_field[20:17], flag_bits[26:21], offset_value[58:27],
  // shifted_value[90:59], shifted_carry[91], zero pad
  output logic [OutWidth-1:0] m_axis_tdata
);

  logic    in_valid;
  item_t   in_item;
  logic    out_valid;
  result_t out_res;
  logic    adv_out;
  result_t res_next;
  dec_t    dec;
  logic [31:0] shv;
  logic        shc;

  assign adv_out       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || adv_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item <= item_t'(s_axis_tdata[$bits(item_t)-1:0]);
    end
  end

  aid_decode u_decode (
    .instruction (in_item.instruction),
    .flags_nzcv  (in_item.flags_nzcv),
    .dec         (dec)
  );

  aid_shifter u_shifter (
    .instruction   (in_item.instruction),
    .carry_in      (in_item.flags_nzcv[1]),
    .rm_value      (in_item.rm_value),
    .rs_value      (in_item.rs_value),
    .shifted_value (shv),
    .shifted_carry (shc)
  );

  always_comb begin
    res_next.dec           = dec;
    res_next.shifted_value = shv;
    res_next.shifted_carry = shc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv_out) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && in_valid) begin
      out_res <= res_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OutWidth - $bits(result_t)){1'b0}}, out_res};

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> in_valid)
    else $error("accepted item not held in input register");

  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    (in_valid && adv_out) |=> out_valid)
    else $error("decoded item lost between stages");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_axis_tready) |=> (out_valid && $stable(out_res)))
    else $error("stalled result changed");

  a_halt_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.dec.inst_kind == KIND_HALT) |->
      (!out_res.dec.regs_valid && out_res.dec.offset_value == 32'd0))
    else $error("halt result carries register or offset fields");

endmodule

// ----- tb/arm_instruction_decode_test.sv -----
`timescale 1ns / 1ps
// self-checking testbench for arm_instruction_decode: directed and random instructions
// go through the stream ports with random idling on both sides; depends on aid_pkg
module arm_instruction_decode_test;
  import aid_pkg::*;

  localparam int QuietTail = 150;
  localparam int StallLimit = 1000;
  localparam int RandomItems = 1150;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InWidth-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutWidth-1:0] m_axis_tdata;

  item_t instr_queue[$];
  result_t predicted_decodes[$];
  int send_gap = 0;
  int stall_gap = 0;
  int errors = 0;
  int quiet_cycles = 0;
  result_t want;
  result_t got;

  arm_instruction_decode u_top (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #1 clk = ~clk;

  function automatic result_t decode_instruction(item_t it);
    result_t r;
    logic [31:0] w;
    logic [31:0] rm;
    logic n, z, c, v;
    logic [63:0] dbl;
    int unsigned amt;
    r = '0;
    w = it.instruction;
    rm = it.rm_value;
    {n, z, c, v} = it.flags_nzcv;
    case (w[27:26])
      TOP_BR:    r.dec.inst_kind = KIND_BRANCH;
      TOP_XFER:  r.dec.inst_kind = KIND_TRANSFER;
      TOP_COPRO: r.dec.inst_kind = KIND_UNSUPPORTED;
      default: begin
        if ((w & MUL_MASK) == MUL_MATCH) r.dec.inst_kind = KIND_MUL;
        else if (w == '0) r.dec.inst_kind = KIND_HALT;
        else r.dec.inst_kind = KIND_DATA;
      end
    endcase
    case (r.dec.inst_kind)
      KIND_DATA: begin
        r.dec.dest_reg = w[15:12];
        r.dec.first_reg = w[19:16];
        r.dec.regs_valid = 1'b1;
        r.dec.opcode_field = w[24:21];
        r.dec.flag_bits = {w[25], w[20], 4'b0000};
        dbl = {24'b0, w[7:0], 24'b0, w[7:0]} >> {w[11:8], 1'b0};
        r.dec.offset_value = dbl[31:0];
      end
      KIND_TRANSFER: begin
        r.dec.dest_reg = w[15:12];
        r.dec.first_reg = w[19:16];
        r.dec.regs_valid = 1'b1;
        r.dec.flag_bits = {w[25], 2'b00, w[24], w[23], w[20]};
        r.dec.offset_value = {20'b0, w[11:0]};
      end
      KIND_MUL: begin
        r.dec.dest_reg = w[19:16];
        r.dec.first_reg = w[15:12];
        r.dec.regs_valid = 1'b1;
        r.dec.flag_bits = {1'b0, w[20], w[21], 3'b000};
      end
      KIND_BRANCH: begin
        r.dec.offset_value = {8'b0, w[23:0]};
      end
      default: ;
    endcase
    r.dec.second_reg = w[3:0];
    case (w[31:28])
      COND_EQ: r.dec.cond_pass = z;
      COND_NE: r.dec.cond_pass = !z;
      COND_CS: r.dec.cond_pass = c;
      COND_CC: r.dec.cond_pass = !c;
      COND_MI: r.dec.cond_pass = n;
      COND_PL: r.dec.cond_pass = !n;
      COND_VS: r.dec.cond_pass = v;
      COND_VC: r.dec.cond_pass = !v;
      COND_HI: r.dec.cond_pass = c && !z;
      COND_LS: r.dec.cond_pass = !c || z;
      COND_GE: r.dec.cond_pass = (n == v);
      COND_LT: r.dec.cond_pass = (n != v);
      COND_GT: r.dec.cond_pass = (n == v) && !z;
      COND_LE: r.dec.cond_pass = (n != v) || z;
      COND_AL: r.dec.cond_pass = 1'b1;
      default: r.dec.cond_pass = 1'b0;
    endcase
    // barrel shifter runs for every class
    amt = w[4] ? 32'(it.rs_value[7:0]) : 32'(w[11:7]);
    r.shifted_value = rm;
    r.shifted_carry = c;
    if (amt != 0) begin
      case (w[6:5])
        SHIFT_LSL: begin
          if (amt < 32) begin
            r.shifted_value = rm << amt;
            r.shifted_carry = rm[32 - amt];
          end else begin
            r.shifted_value = '0;
            r.shifted_carry = (amt == 32) ? rm[0] : 1'b0;
          end
        end
        SHIFT_LSR: begin
          if (amt < 32) begin
            r.shifted_value = rm >> amt;
            r.shifted_carry = rm[amt - 1];
          end else begin
            r.shifted_value = '0;
            r.shifted_carry = (amt == 32) ? rm[31] : 1'b0;
          end
        end
        SHIFT_ASR: begin
          if (amt < 32) begin
            r.shifted_value = $signed(rm) >>> amt;
            r.shifted_carry = rm[amt - 1];
          end else begin
            r.shifted_value = {32{rm[31]}};
            r.shifted_carry = rm[31];
          end
        end
        default: begin
          if (amt % 32 == 0) begin
            r.shifted_carry = rm[31];
          end else begin
            dbl = {rm, rm} >> (amt % 32);
            r.shifted_value = dbl[31:0];
            r.shifted_carry = dbl[31];
          end
        end
      endcase
    end
    return r;
  endfunction

  function automatic logic [31:0] random_instruction();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 9))
      0: ;
      1: w = (w & ~MUL_MASK) | MUL_MATCH;
      2: w = ($urandom_range(0, 3) == 0) ? '0 : {w[31:28], 2'b00, w[25:0]};
      3, 4: w[27:26] = 2'b00;
      5: w[27:26] = TOP_XFER;
      6: w[27:26] = TOP_BR;
      7: w[27:26] = TOP_COPRO;
      default: w[27:25] = 3'b000;
    endcase
    return w;
  endfunction

  task automatic add_item(logic [31:0] w, logic [3:0] f, logic [31:0] rm, logic [31:0] rs);
    item_t it;
    it.instruction = w;
    it.flags_nzcv = f;
    it.rm_value = rm;
    it.rs_value = rs;
    instr_queue.push_back(it);
  endtask

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, act_val);
      errors++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) instr_queue.delete(0);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap == 0 && instr_queue.size() >= QuietTail && $urandom_range(0, 7) == 0)
          send_gap = $urandom_range(1, 6);
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (instr_queue.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= InWidth'(instr_queue[0]);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
        if (predicted_decodes.size() == 0) begin
          $error("unexpected item on output: %0h", m_axis_tdata);
          errors++;
        end else begin
          want = predicted_decodes.pop_front();
          check_field("inst_kind", 32'(want.dec.inst_kind), 32'(got.dec.inst_kind));
          check_field("cond_pass", 32'(want.dec.cond_pass), 32'(got.dec.cond_pass));
          check_field("dest_reg", 32'(want.dec.dest_reg), 32'(got.dec.dest_reg));
          check_field("first_reg", 32'(want.dec.first_reg), 32'(got.dec.first_reg));
          check_field("second_reg", 32'(want.dec.second_reg), 32'(got.dec.second_reg));
          check_field("regs_valid", 32'(want.dec.regs_valid), 32'(got.dec.regs_valid));
          check_field("opcode_field", 32'(want.dec.opcode_field),
                      32'(got.dec.opcode_field));
          check_field("flag_bits", 32'(want.dec.flag_bits), 32'(got.dec.flag_bits));
          check_field("offset_value", want.dec.offset_value, got.dec.offset_value);
          check_field("shifted_value", want.shifted_value, got.shifted_value);
          check_field("shifted_carry", 32'(want.shifted_carry), 32'(got.shifted_carry));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        predicted_decodes.push_back(
          decode_instruction(item_t'(s_axis_tdata[$bits(item_t)-1:0])));
      if (stall_gap == 0 && instr_queue.size() >= QuietTail && $urandom_range(0, 7) == 0)
        stall_gap = $urandom_range(1, 6);
      if (stall_gap > 0) begin
        stall_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [31:0] rs_rand;
    logic [31:0] rm_val;
    logic [7:0] amount;
    // conditions with the shifter corner cases, data processing with immediate and register shifts
    add_item(32'h01A0_3000, 4'b0100, 32'h8000_0001, 32'h0000_0000);
    add_item(32'h11A0_3020, 4'b0010, 32'hDEAD_BEEF, 32'h0000_0000);
    add_item(32'h21A0_3040, 4'b0000, 32'h8000_0000, 32'h0000_0000);
    add_item(32'h31A0_3060, 4'b1111, 32'h1234_5678, 32'h0000_0000);
    add_item(32'h41A0_3011, 4'b1000, 32'h0000_0003, 32'h0000_0020);
    add_item(32'h51A0_3032, 4'b0000, 32'h8000_0000, 32'h0000_0020);
    add_item(32'h61A0_3053, 4'b0001, 32'h8000_1234, 32'h0000_0028);
    add_item(32'h71A0_3074, 4'b0000, 32'h8765_4321, 32'h0000_0020);
    add_item(32'h81A0_3015, 4'b0010, 32'hFFFF_FFFF, 32'h0000_0021);
    add_item(32'h91A0_3036, 4'b0010, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_item(32'h91A0_3077, 4'b0100, 32'hF000_000F, 32'h0000_0040);
    add_item(32'hA1A0_3F88, 4'b1001, 32'h0000_0001, 32'h0000_0000);
    add_item(32'hB1A0_30C9, 4'b1000, 32'h8000_0001, 32'h0000_0000);
    add_item(32'hC1A0_3FEA, 4'b0000, 32'h0000_0001, 32'h0000_0000);
    add_item(32'hD1A0_303B, 4'b0100, 32'hAAAA_5555, 32'hFFFF_FF00);
    add_item(32'hE1A0_305C, 4'b0000, 32'h7FFF_FFFF, 32'h0000_001F);
    add_item(32'hF1A0_300D, 4'b1111, 32'h0F0F_0F0F, 32'h0000_0001);
    // each class at least once, plus a near-multiply that is data processing
    add_item(32'h0000_0000, 4'b0000, 32'h0000_0000, 32'h0000_0000);
    add_item(32'hFFFF_FFFF, 4'b1111, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_item(32'hE031_2394, 4'b0010, 32'h0000_00F0, 32'h0000_0005);
    add_item(32'hE3B0_14FF, 4'b0000, 32'h0000_0000, 32'h0000_0000);
    add_item(32'hE59F_1FFF, 4'b0000, 32'h0000_0000, 32'h0000_0000);
    add_item(32'hEAFF_FFFF, 4'b0000, 32'h0000_0000, 32'h0000_0000);
    add_item(32'hEE00_0F10, 4'b0000, 32'h0000_0000, 32'h0000_0000);
    add_item(32'h0040_0090, 4'b0100, 32'h0000_0000, 32'h0000_0000);
    for (int i = 0; i < RandomItems; i++) begin
      case ($urandom_range(0, 7))
        0: rm_val = 32'h0000_0000;
        1: rm_val = 32'hFFFF_FFFF;
        2: rm_val = 32'h8000_0000;
        default: rm_val = $urandom;
      endcase
      case ($urandom_range(0, 5))
        0: amount = 8'($urandom_range(0, 31));
        1: amount = 8'd32;
        2: amount = 8'($urandom_range(33, 64));
        3: amount = 8'($urandom_range(65, 255));
        4: amount = 8'd0;
        default: amount = 8'($urandom_range(0, 40));
      endcase
      rs_rand = $urandom;
      add_item(random_instruction(), 4'($urandom_range(0, 15)), rm_val,
               {rs_rand[31:8], amount});
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    while (instr_queue.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (predicted_decodes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/aid_pkg.sv
hw/rtl/aid_decode.sv
hw/rtl/aid_shifter.sv
hw/rtl/arm_instruction_decode.sv
tb/arm_instruction_decode_test.sv
